// ----- sv/gfb_pkg.sv -----
// ----------------------------------------------------------------------------
// gfb_pkg
// Shared types and codes of the glyph blitter: register indexes, raster op
// codes and the request and result records passed between the units.
// ----------------------------------------------------------------------------
package gfb_pkg;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FG_COLOR   = 2'd0;
  localparam cfg_idx_t CFG_BG_COLOR   = 2'd1;
  localparam cfg_idx_t CFG_WRITE_MODE = 2'd2;

  // raster op codes
  typedef logic [1:0] rop_t;
  localparam rop_t ROP_REPLACE = 2'd0;
  localparam rop_t ROP_XOR     = 2'd1;
  localparam rop_t ROP_OR      = 2'd2;
  localparam rop_t ROP_AND     = 2'd3;

  localparam int unsigned PIXEL_W    = 16;
  localparam int unsigned OUT_ADDR_W = 17;

  // output queue depth
  localparam int unsigned OFIFO_DEPTH = 4;
  localparam int unsigned OFIFO_PTR_W = 2;

  // one pixel request from the sequencer to the read-modify-write unit
  typedef struct packed {
    logic               valid;
    logic [PIXEL_W-1:0] color;
    logic               last;
  } pix_req_t;

  // one finished pixel
  typedef struct packed {
    logic                  valid;
    logic [OUT_ADDR_W-1:0] addr;
    logic [PIXEL_W-1:0]    value;
    logic                  last;
  } pix_res_t;

endpackage

// ----- sv/gfb_in_if.sv -----
// ----------------------------------------------------------------------------
// gfb_in_if
// Glyph byte channel: valid/ready handshake with the character cell payload.
// ----------------------------------------------------------------------------
interface gfb_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] pos_x;
  logic [7:0] pos_y;
  logic [6:0] char_width;
  logic [6:0] char_height;
  logic [7:0] glyph_byte;

  modport source (output valid, pos_x, pos_y, char_width, char_height, glyph_byte,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, char_width, char_height, glyph_byte,
                  output ready);
endinterface

// ----- sv/gfb_out_if.sv -----
// ----------------------------------------------------------------------------
// gfb_out_if
// Written pixel channel: valid/ready handshake with address, value and flag.
// ----------------------------------------------------------------------------
interface gfb_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] pixel_addr;
  logic [15:0] pixel_value;
  logic        last_of_char;

  modport source (output valid, pixel_addr, pixel_value, last_of_char, input ready);
  modport sink   (input valid, pixel_addr, pixel_value, last_of_char, output ready);
endinterface

// ----- sv/gfb_seq.sv -----
// ----------------------------------------------------------------------------
// gfb_seq
// Glyph byte decoder and pixel sequencer: tracks the character row and byte,
// finds the start address and issues one pixel a cycle while queue has room.
// ----------------------------------------------------------------------------
module gfb_seq #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240,
  parameter int unsigned LINE_PITCH    = 320,
  parameter int unsigned DEPTH         = 76800,
  parameter int unsigned ADDR_W        = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clearing,
  input  logic                        space_ok,
  input  logic [gfb_pkg::PIXEL_W-1:0] fg_color,
  input  logic [gfb_pkg::PIXEL_W-1:0] bg_color,
  gfb_in_if.sink                      in_ch,
  output gfb_pkg::pix_req_t           pix,
  output logic [ADDR_W-1:0]           pix_addr
);

  localparam int unsigned SUM_W = $clog2(DEPTH + SCREEN_WIDTH + 1);

  // position within the character
  logic [5:0]       row_count;
  logic [2:0]       byte_in_row;

  // pixel run of the current byte
  logic             busy;
  logic [SUM_W-1:0] cur_addr;
  logic [3:0]       remain;
  logic [7:0]       bits;
  logic             last_char;

  // byte decode
  logic             dims_ok;
  logic [3:0]       bpr;
  logic             row_end;
  logic             char_end;
  logic [5:0]       col0;
  logic [6:0]       span;
  logic [3:0]       n;
  logic             visible;
  logic [8:0]       y;
  logic [SUM_W-1:0] base;

  logic             accept;
  logic             issue;
  logic             wrap_step;
  logic             last_issue;

  always_comb begin
    dims_ok = (in_ch.char_width != 7'd0) && (in_ch.char_width <= 7'd64) &&
              (in_ch.char_height != 7'd0) && (in_ch.char_height <= 7'd64);
    bpr      = 4'(({1'b0, in_ch.char_width} + 8'd7) >> 3);
    row_end  = ({1'b0, byte_in_row} + 4'd1) >= bpr;
    char_end = row_end && (({1'b0, row_count} + 7'd1) >= in_ch.char_height);
    col0     = {byte_in_row, 3'b000};
    span     = in_ch.char_width - {1'b0, col0};
    // pixels left in this byte, clipped to eight
    if ({1'b0, col0} >= in_ch.char_width) begin
      n = 4'd0;
    end else if (span > 7'd8) begin
      n = 4'd8;
    end else begin
      n = span[3:0];
    end
    if ({1'b0, row_count} >= in_ch.char_height) begin
      n = 4'd0;
    end
    visible = (({2'b00, in_ch.pos_x} + {4'b0000, in_ch.char_width}) <=
               11'(SCREEN_WIDTH)) &&
              (({3'b000, in_ch.pos_y} + {4'b0000, in_ch.char_height}) <=
               11'(SCREEN_HEIGHT));
    y    = {1'b0, in_ch.pos_y} + {3'b000, row_count};
    base = SUM_W'(SUM_W'(y) * SUM_W'(LINE_PITCH)) + SUM_W'(in_ch.pos_x) + SUM_W'(col0);
  end

  // issue control
  assign wrap_step  = busy && (cur_addr >= SUM_W'(DEPTH));
  assign issue      = busy && !wrap_step && space_ok;
  assign last_issue = issue && (remain == 4'd1);
  assign in_ch.ready = !clearing && (!busy || last_issue);
  assign accept     = in_ch.valid && in_ch.ready;

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= 6'd0;
      byte_in_row <= 3'd0;
    end else if (accept && dims_ok) begin
      if (row_end) begin
        byte_in_row <= 3'd0;
        row_count   <= char_end ? 6'd0 : row_count + 6'd1;
      end else begin
        byte_in_row <= byte_in_row + 3'd1;
      end
    end
  end

  // pixel run
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && dims_ok && visible && (n != 4'd0)) begin
      busy <= 1'b1;
    end else if (last_issue) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_addr  <= base;
      remain    <= n;
      bits      <= in_ch.glyph_byte;
      last_char <= char_end;
    end else if (wrap_step) begin
      cur_addr <= cur_addr - SUM_W'(DEPTH);
    end else if (issue) begin
      cur_addr <= (cur_addr == SUM_W'(DEPTH - 1)) ? '0 : cur_addr + SUM_W'(1);
      remain   <= remain - 4'd1;
      bits     <= {bits[6:0], 1'b0};
    end
  end

  // pixel request
  always_comb begin
    pix.valid = issue;
    pix.color = bits[7] ? fg_color : bg_color;
    pix.last  = last_char && (remain == 4'd1);
    pix_addr  = ADDR_W'(cur_addr);
  end

endmodule

// ----- sv/gfb_rmw.sv -----
// ----------------------------------------------------------------------------
// gfb_rmw
// Framebuffer memory with read-modify-write pipeline: reads the old pixel,
// applies the raster op in the cycle after and writes back, forwarding the
// previous write when it hits the same address. Clears the memory on reset.
// ----------------------------------------------------------------------------
module gfb_rmw #(
  parameter int unsigned DEPTH  = 76800,
  parameter int unsigned ADDR_W = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  gfb_pkg::pix_req_t   pix,
  input  logic [ADDR_W-1:0]   pix_addr,
  input  gfb_pkg::rop_t       write_mode,
  output logic                clearing,
  output gfb_pkg::pix_res_t   res
);

  logic [gfb_pkg::PIXEL_W-1:0] mem [DEPTH];

  logic [ADDR_W-1:0]           clr_addr;

  // modify stage
  logic                        m_valid;
  logic [ADDR_W-1:0]           m_addr;
  logic [gfb_pkg::PIXEL_W-1:0] m_color;
  logic                        m_last;
  logic                        fwd_hit;
  logic [gfb_pkg::PIXEL_W-1:0] fwd_val;
  logic [gfb_pkg::PIXEL_W-1:0] rd_q;

  logic [gfb_pkg::PIXEL_W-1:0] old_val;
  logic [gfb_pkg::PIXEL_W-1:0] new_val;

  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [gfb_pkg::PIXEL_W-1:0] wr_data;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // raster op on the old pixel, forwarded when the last write hit it
  always_comb begin
    old_val = fwd_hit ? fwd_val : rd_q;
    unique case (write_mode)
      gfb_pkg::ROP_XOR: new_val = old_val ^ m_color;
      gfb_pkg::ROP_OR:  new_val = old_val | m_color;
      gfb_pkg::ROP_AND: new_val = old_val & m_color;
      default:          new_val = m_color;
    endcase
  end

  // write port
  always_comb begin
    wr_en   = clearing || m_valid;
    wr_addr = clearing ? clr_addr : m_addr;
    wr_data = clearing ? '0 : new_val;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (pix.valid) begin
      rd_q <= mem[pix_addr];
    end
  end

  // modify stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid) begin
      m_addr  <= pix_addr;
      m_color <= pix.color;
      m_last  <= pix.last;
      fwd_hit <= m_valid && (m_addr == pix_addr);
      fwd_val <= new_val;
    end
  end

  // finished pixel
  always_comb begin
    res.valid = m_valid;
    res.addr  = gfb_pkg::OUT_ADDR_W'(m_addr);
    res.value = new_val;
    res.last  = m_last;
  end

endmodule

// ----- sv/gfb_ofifo.sv -----
// ----------------------------------------------------------------------------
// gfb_ofifo
// Output queue for written pixels; reports room for one more request so that
// the pipeline ahead of it never has to stall.
// ----------------------------------------------------------------------------
module gfb_ofifo (
  input  logic              clk,
  input  logic              rst,
  input  gfb_pkg::pix_res_t res,
  output logic              space_ok,
  gfb_out_if.source         out_ch
);

  localparam int unsigned CNT_W = gfb_pkg::OFIFO_PTR_W + 1;

  logic [gfb_pkg::OUT_ADDR_W-1:0] q_addr  [gfb_pkg::OFIFO_DEPTH];
  logic [gfb_pkg::PIXEL_W-1:0]    q_value [gfb_pkg::OFIFO_DEPTH];
  logic                           q_last  [gfb_pkg::OFIFO_DEPTH];

  logic [gfb_pkg::OFIFO_PTR_W-1:0] wr_ptr;
  logic [gfb_pkg::OFIFO_PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]                count;
  logic                            pop;

  assign pop      = out_ch.valid && out_ch.ready;
  // room counts the request already in the modify stage
  assign space_ok = (count + CNT_W'(res.valid)) < CNT_W'(gfb_pkg::OFIFO_DEPTH);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr <= wr_ptr + gfb_pkg::OFIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gfb_pkg::OFIFO_PTR_W'(1);
      end
      count <= count + CNT_W'(res.valid) - CNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (res.valid) begin
      q_addr[wr_ptr]  <= res.addr;
      q_value[wr_ptr] <= res.value;
      q_last[wr_ptr]  <= res.last;
    end
  end

  // head of queue
  assign out_ch.valid        = (count != '0);
  assign out_ch.pixel_addr   = q_addr[rd_ptr];
  assign out_ch.pixel_value  = q_value[rd_ptr];
  assign out_ch.last_of_char = q_last[rd_ptr];

endmodule

// ----- sv/glyph_to_framebuffer_blit.sv -----
// ----------------------------------------------------------------------------
// glyph_to_framebuffer_blit
// Monochrome glyph blitter drawing into a 16-bit framebuffer with raster op.
// ----------------------------------------------------------------------------
// Each glyph byte turns into up to eight pixel read-modify-writes on the
// framebuffer memory, one pixel per cycle while the output queue has room,
// and the next byte is taken in the cycle its last pixel is issued; bytes
// that draw nothing are taken at one per cycle. The memory has one read and
// one write port, the pixel is read in one cycle and written back the next,
// with the preceding write forwarded. After reset the block clears the
// framebuffer and takes no glyph bytes meanwhile; configuration writes are
// taken at any time. Written pixels wait in a four-entry output queue, which
// holds back the sequencer when full. With a line pitch narrower than the
// screen, an address past the end of the framebuffer is wrapped to the start
// in a separate step that holds back the pixel issue.
// ----------------------------------------------------------------------------
module glyph_to_framebuffer_blit #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240,
  parameter int unsigned LINE_PITCH    = 320
) (
  input  logic                        clk,
  input  logic                        rst,
  gfb_in_if.sink                      in_ch,
  gfb_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  gfb_pkg::cfg_idx_t           cfg_index,
  input  logic [gfb_pkg::PIXEL_W-1:0] cfg_data
);

  localparam int unsigned DEPTH  = SCREEN_HEIGHT * LINE_PITCH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [gfb_pkg::PIXEL_W-1:0] fg_color;
  logic [gfb_pkg::PIXEL_W-1:0] bg_color;
  gfb_pkg::rop_t               write_mode;

  logic                        clearing;
  logic                        space_ok;
  gfb_pkg::pix_req_t           pix;
  logic [ADDR_W-1:0]           pix_addr;
  gfb_pkg::pix_res_t           res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color   <= '1;
      bg_color   <= '0;
      write_mode <= gfb_pkg::ROP_REPLACE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfb_pkg::CFG_FG_COLOR:   fg_color   <= cfg_data;
        gfb_pkg::CFG_BG_COLOR:   bg_color   <= cfg_data;
        gfb_pkg::CFG_WRITE_MODE: write_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // byte decode and pixel sequencing
  gfb_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .LINE_PITCH    (LINE_PITCH),
    .DEPTH         (DEPTH),
    .ADDR_W        (ADDR_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .space_ok (space_ok),
    .fg_color (fg_color),
    .bg_color (bg_color),
    .in_ch    (in_ch),
    .pix      (pix),
    .pix_addr (pix_addr)
  );

  // framebuffer read-modify-write
  gfb_rmw #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_rmw (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .pix_addr   (pix_addr),
    .write_mode (write_mode),
    .clearing   (clearing),
    .res        (res)
  );

  // output queue
  gfb_ofifo u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph blitter. A short table of directed glyph
// bytes and register writes comes first, then phases of random characters
// under different colours and raster ops. Every accepted byte goes through a
// local model of the blitter with its own framebuffer copy, and each written
// pixel leaving the block is compared with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCREEN_W     = 320;
  localparam int unsigned SCREEN_H     = 240;
  localparam int unsigned PITCH        = 320;
  localparam int unsigned FRAME_PIXELS = SCREEN_H * PITCH;
  localparam int unsigned ITEM_TARGET  = 430;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 52;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [8:0] pos_x;
    logic [7:0] pos_y;
    logic [6:0] char_width;
    logic [6:0] char_height;
    logic [7:0] glyph_byte;
  } glyph_t;

  typedef struct packed {
    logic [16:0] addr;
    logic [15:0] value;
    logic        last;
  } pixel_t;

  typedef enum logic {ROW_CFG, ROW_GLYPH} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    gfb_pkg::cfg_idx_t  reg_sel;
    logic [15:0]        reg_val;
    glyph_t             g;
    int                 typed_n;
    pixel_t             want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic              cfg_we;
  gfb_pkg::cfg_idx_t cfg_index;
  logic [15:0]       cfg_data;

  gfb_in_if  in_ch();
  gfb_out_if out_ch();

  glyph_to_framebuffer_blit #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H),
    .LINE_PITCH    (PITCH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state: framebuffer copy, glyph counters and registers
  logic [15:0]   frame_mem [FRAME_PIXELS];
  logic [5:0]    glyph_row;
  logic [2:0]    byte_col;
  logic [15:0]   fg_now;
  logic [15:0]   bg_now;
  gfb_pkg::rop_t rop_now;

  pixel_t      pixel_due_q[$];
  dir_row_t    dir_tab[$];
  int unsigned items_sent;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  bit          send_idle_on;
  bit          recv_idle_on;
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %0s: got %h, want %h (cycle %0d)", what, got, want, cycle_cnt);
    mismatches++;
  endtask

  function automatic bit dims_ok(input glyph_t g);
    return g.char_width != 0 && g.char_width <= 64 &&
           g.char_height != 0 && g.char_height <= 64;
  endfunction

  // draw one glyph byte into the framebuffer copy, queue the written pixels
  function automatic int unsigned blit_glyph_byte(input glyph_t g);
    int unsigned w, h, bpr, row, col0, n, y, x, addr;
    logic [15:0] color, nv;
    bit row_end, char_end, visible;
    if (!dims_ok(g)) return 0;
    w        = g.char_width;
    h        = g.char_height;
    bpr      = (w + 7) / 8;
    row      = glyph_row;
    col0     = byte_col * 8;
    row_end  = (byte_col + 1 >= bpr);
    char_end = row_end && (row + 1 >= h);
    visible  = (g.pos_x + w <= SCREEN_W) && (g.pos_y + h <= SCREEN_H);
    n = (col0 < w) ? w - col0 : 0;
    if (n > 8) n = 8;
    if (row >= h) n = 0;
    if (!visible) n = 0;
    for (int k = 0; k < int'(n); k++) begin
      y     = g.pos_y + row;
      x     = g.pos_x + col0 + k;
      addr  = (y * PITCH + x) % FRAME_PIXELS;
      color = g.glyph_byte[7-k] ? fg_now : bg_now;
      case (rop_now)
        gfb_pkg::ROP_XOR: nv = frame_mem[addr] ^ color;
        gfb_pkg::ROP_OR:  nv = frame_mem[addr] | color;
        gfb_pkg::ROP_AND: nv = frame_mem[addr] & color;
        default:          nv = color;
      endcase
      frame_mem[addr] = nv;
      pixel_due_q.push_back(pixel_t'{addr[16:0], nv, char_end && (k + 1 == n)});
    end
    // counters wrap once the character is complete
    if (row_end) begin
      byte_col  = '0;
      glyph_row = char_end ? 6'd0 : 6'(row + 1);
    end else begin
      byte_col = byte_col + 3'd1;
    end
    return n;
  endfunction

  // present one glyph byte, wait for the request to be taken
  task automatic send_byte(input glyph_t g, input int typed_n = -1,
                           input pixel_t want = '0);
    int unsigned n_drawn;
    @(negedge clk);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.pos_x       = g.pos_x;
    in_ch.pos_y       = g.pos_y;
    in_ch.char_width  = g.char_width;
    in_ch.char_height = g.char_height;
    in_ch.glyph_byte  = g.glyph_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_drawn = blit_glyph_byte(g);
    // table rows with a typed answer replace what the model queued
    if (typed_n >= 0) begin
      repeat (n_drawn) void'(pixel_due_q.pop_back());
      if (typed_n > 0) pixel_due_q.push_back(want);
    end
    if (dims_ok(g)) items_sent++;
  endtask

  // stop requests and let every pending pixel come out
  task automatic drain_pixels();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pixel_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input gfb_pkg::cfg_idx_t sel, input logic [15:0] val);
    drain_pixels();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    case (sel)
      gfb_pkg::CFG_FG_COLOR:   fg_now = val;
      gfb_pkg::CFG_BG_COLOR:   bg_now = val;
      gfb_pkg::CFG_WRITE_MODE: rop_now = gfb_pkg::rop_t'(val[1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_glyph(input int unsigned px, py, w, h, nbytes);
    glyph_t g;
    g.pos_x       = 9'(px);
    g.pos_y       = 8'(py);
    g.char_width  = 7'(w);
    g.char_height = 7'(h);
    for (int unsigned i = 0; i < nbytes; i++) begin
      case ($urandom_range(0, 7))
        0:       g.glyph_byte = 8'h00;
        1:       g.glyph_byte = 8'hFF;
        default: g.glyph_byte = 8'($urandom);
      endcase
      send_byte(g);
    end
  endtask

  // one random character: mostly whole visible glyphs, some off screen,
  // some cut short, some single bytes with any field values
  task automatic send_random_glyph();
    int unsigned kind, w, h, px, py;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          w = $urandom_range(33, 64);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 8);
          h = $urandom_range(40, 64);
        end
      end else begin
        w = $urandom_range(1, 20);
        h = $urandom_range(1, 6);
      end
      px = $urandom_range(0, SCREEN_W - w);
      py = $urandom_range(0, SCREEN_H - h);
      send_glyph(px, py, w, h, ((w + 7) / 8) * h);
    end else if (kind < 80) begin
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 1) == 1) begin
        px = $urandom_range(SCREEN_W + 1 - w, 511);
        py = $urandom_range(0, 255);
      end else begin
        px = $urandom_range(0, 511);
        py = $urandom_range(SCREEN_H + 1 - h, 255);
      end
      send_glyph(px, py, w, h, ((w + 7) / 8) * h);
    end else if (kind < 90) begin
      w  = $urandom_range(1, 24);
      h  = $urandom_range(1, 5);
      px = $urandom_range(0, SCREEN_W - w);
      py = $urandom_range(0, SCREEN_H - h);
      send_glyph(px, py, w, h, $urandom_range(1, ((w + 7) / 8) * h));
    end else begin
      send_glyph($urandom_range(0, 511), $urandom_range(0, 255),
                 $urandom_range(0, 127), $urandom_range(0, 127), 1);
    end
  endtask

  function automatic void row_cfg(input gfb_pkg::cfg_idx_t sel, input logic [15:0] val);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = val;
    r.g       = '0;
    r.typed_n = -1;
    r.want    = '0;
    dir_tab.push_back(r);
  endfunction

  function automatic void row_glyph(input int unsigned px, py, w, h,
                                    input logic [7:0] b, input int typed_n = -1,
                                    input int unsigned addr = 0,
                                    input logic [15:0] val = '0,
                                    input logic last = 1'b0);
    dir_row_t r;
    r.kind    = ROW_GLYPH;
    r.reg_sel = gfb_pkg::CFG_FG_COLOR;
    r.reg_val = '0;
    r.g       = glyph_t'{9'(px), 8'(py), 7'(w), 7'(h), b};
    r.typed_n = typed_n;
    r.want    = pixel_t'{17'(addr), val, last};
    dir_tab.push_back(r);
  endfunction

  // receiver: random stall bursts while enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(0, 18);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // compare each written pixel with the oldest prediction
  always @(posedge clk) begin : pixel_check
    pixel_t due;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pixel_due_q.size() == 0) begin
        flag_mismatch("unexpected pixel at addr", 32'(out_ch.pixel_addr), '0);
      end else begin
        due = pixel_due_q.pop_front();
        if (out_ch.pixel_addr !== due.addr)
          flag_mismatch("pixel_addr", 32'(out_ch.pixel_addr), 32'(due.addr));
        if (out_ch.pixel_value !== due.value)
          flag_mismatch("pixel_value", 32'(out_ch.pixel_value), 32'(due.value));
        if (out_ch.last_of_char !== due.last)
          flag_mismatch("last_of_char", 32'(out_ch.last_of_char), 32'(due.last));
      end
    end
  end

  initial begin : stimulus
    logic [7:0]    wide_bytes [8];
    gfb_pkg::rop_t rop_seq [4];
    int unsigned   phase_goal;
    // known values on the block inputs from the start
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = gfb_pkg::CFG_FG_COLOR;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.char_width  = '0;
    in_ch.char_height = '0;
    in_ch.glyph_byte  = '0;
    items_sent        = 0;
    send_idle_on      = 1'b1;
    recv_idle_on      = 1'b1;
    // model reset
    foreach (frame_mem[i]) frame_mem[i] = '0;
    glyph_row = '0;
    byte_col  = '0;
    fg_now    = 16'hFFFF;
    bg_now    = 16'h0000;
    rop_now   = gfb_pkg::ROP_REPLACE;
    wide_bytes = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'hF0, 8'h0F};
    rop_seq    = '{gfb_pkg::ROP_REPLACE, gfb_pkg::ROP_XOR, gfb_pkg::ROP_OR,
                   gfb_pkg::ROP_AND};

    // lone pixels in both corners with the reset colours
    row_glyph(0,   0,   1, 1, 8'h80, 1, 0,     16'hFFFF, 1'b1);
    row_glyph(319, 239, 1, 1, 8'h00, 1, 76799, 16'h0000, 1'b1);
    // bad dimensions are dropped
    row_glyph(0, 0, 0,   1,   8'hFF, 0);
    row_glyph(0, 0, 1,   0,   8'hFF, 0);
    row_glyph(0, 0, 65,  1,   8'hFF, 0);
    row_glyph(0, 0, 127, 127, 8'hFF, 0);
    // cells past the screen edge are consumed but not drawn
    row_glyph(320, 0,   1, 1, 8'hFF, 0);
    row_glyph(511, 255, 1, 1, 8'hFF, 0);
    // widest glyph flush with the right edge
    foreach (wide_bytes[i]) row_glyph(256, 128, 64, 1, wide_bytes[i]);
    // nine pixel row, pad bits of the second byte ignored
    row_glyph(0, 1, 9, 1, 8'hFF);
    row_glyph(0, 1, 9, 1, 8'hFF);
    // width shrinks part way through a row
    row_glyph(10, 10, 16, 2, 8'hF0);
    row_glyph(10, 10, 8,  2, 8'hFF);
    row_glyph(10, 10, 8,  2, 8'h0F);
    // each raster op on the first pixel
    row_cfg(gfb_pkg::CFG_WRITE_MODE, 16'(gfb_pkg::ROP_XOR));
    row_cfg(gfb_pkg::CFG_FG_COLOR, 16'h1234);
    row_glyph(0, 0, 1, 1, 8'h80, 1, 0, 16'hEDCB, 1'b1);
    row_cfg(gfb_pkg::CFG_WRITE_MODE, 16'(gfb_pkg::ROP_OR));
    row_cfg(gfb_pkg::CFG_BG_COLOR, 16'h00F0);
    row_glyph(0, 0, 1, 1, 8'h00, 1, 0, 16'hEDFB, 1'b1);
    row_cfg(gfb_pkg::CFG_WRITE_MODE, 16'(gfb_pkg::ROP_AND));
    row_cfg(gfb_pkg::CFG_FG_COLOR, 16'h0F0F);
    row_glyph(0, 0, 1, 1, 8'h80, 1, 0, 16'h0D0B, 1'b1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
      end else begin
        send_byte(dir_tab[i].g, dir_tab[i].typed_n, dir_tab[i].want);
      end
    end

    // random phases, each with its own colours, raster op and idling
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      send_idle_on = (p % 3 != 2) && (p != NUM_PHASES - 1);
      recv_idle_on = (p % 3 != 1) && (p != NUM_PHASES - 1);
      if (p == 0) begin
        write_reg(gfb_pkg::CFG_FG_COLOR, 16'hFFFF);
        write_reg(gfb_pkg::CFG_BG_COLOR, 16'h0000);
      end else if (p == 1) begin
        write_reg(gfb_pkg::CFG_FG_COLOR, 16'h0000);
        write_reg(gfb_pkg::CFG_BG_COLOR, 16'hFFFF);
      end else begin
        write_reg(gfb_pkg::CFG_FG_COLOR, 16'($urandom));
        write_reg(gfb_pkg::CFG_BG_COLOR, 16'($urandom));
      end
      write_reg(gfb_pkg::CFG_WRITE_MODE, 16'(rop_seq[p % 4]));
      phase_goal = (p == NUM_PHASES - 1) ? ITEM_TARGET : items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) send_random_glyph();
    end

    drain_pixels();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gfb_pkg.sv
sv/gfb_in_if.sv
sv/gfb_out_if.sv
sv/gfb_seq.sv
sv/gfb_rmw.sv
sv/gfb_ofifo.sv
sv/glyph_to_framebuffer_blit.sv
dv/tb_top.sv
